// ===== rtl/tcce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg: shared definitions of the text console character engine
// Default geometry, field widths, command and character codes, and the
// sequencer state type.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TERMINALS_DEF = 2;
    localparam int TAB_STOP_DEF  = 8;

    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int POS_W    = 8;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    localparam logic [CMD_W-1:0] CMD_PUT        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT_ATTR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_ATTR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd0;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_BLANK,
        ST_DISPATCH,
        ST_DIV,
        ST_MOD,
        ST_FILL,
        ST_MUL,
        ST_SET,
        ST_RD_REQ,
        ST_RD_DATA,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/tcce_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/text_console_character_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_character_engine: multi-screen character-cell console
// Keeps TERMINALS screens of ROWS x COLUMNS cells with a cursor and a current
// attribute each, and executes put, cursor, attribute, clear and read
// commands under a small sequencer.
// ----------------------------------------------------------------------------
// After reset the cell memory is swept to zero, one cell per cycle, before the
// first command transfer is taken. One command is executed at a time. Set
// cursor passes through the multiplier stage, and read cell also through the
// registered read of the cell memory. Newline, carriage return and tab first
// find the column by repeated subtraction in a shared compare-and-subtract
// unit, one step per cycle (up to ROWS steps, and for tab up to
// COLUMNS/TAB_STOP more); newline and tab then blank one cell per cycle.
// Clear writes all ROWS*COLUMNS cells of the screen, one cell per cycle. A put
// on a full screen first scrolls: each of the (ROWS-1)*COLUMNS moved cells is
// read and then written, and the COLUMNS cells of the new row are blanked.
module text_console_character_engine
    import tcce_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TERMINALS = TERMINALS_DEF,
    parameter int TAB_STOP  = TAB_STOP_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic                terminal,
    input  wire logic [CHAR_W-1:0]   ch,
    input  wire logic [ATTR_W-1:0]   attribute,
    input  wire logic [POS_W-1:0]    row,
    input  wire logic [POS_W-1:0]    col,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [CURSOR_W-1:0] cursor,
    output logic      [CHAR_W-1:0]   cell_char,
    output logic      [ATTR_W-1:0]   cell_attribute
);

    localparam int SCREEN_SIZE = ROWS * COLUMNS;
    localparam int DEPTH       = TERMINALS * SCREEN_SIZE;
    localparam int AW          = $clog2(DEPTH);
    localparam int CUR_W       = $clog2(SCREEN_SIZE + 1);
    localparam int COL_W       = $clog2(COLUMNS + 1);
    localparam int MOD_W       = $clog2(TAB_STOP + 1);
    localparam int PROD_W      = POS_W + COL_W;
    localparam int TIDX_W      = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    state_t state_reg;
    state_t state_next;

    logic [AW-1:0]     init_ptr_reg;
    logic              out_valid_reg;
    logic [CUR_W-1:0]  cursor_pos_reg [0:TERMINALS-1];
    logic [ATTR_W-1:0] cur_attr_reg   [0:TERMINALS-1];
    logic              t_ok_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [ATTR_W-1:0] wattr_reg;
    logic [ATTR_W-1:0] cattr_reg;
    logic [POS_W-1:0]  row_in_reg;
    logic [POS_W-1:0]  col_in_reg;
    logic [AW-1:0]     base_reg;
    logic [TIDX_W-1:0] tsel_reg;
    logic [CUR_W-1:0]  cur_reg;
    logic [CUR_W-1:0]  rem_reg;
    logic [COL_W-1:0]  col_reg;
    logic [MOD_W-1:0]  mod_reg;
    logic [CUR_W-1:0]  ptr_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CHAR_W-1:0] rd_char_reg;
    logic [ATTR_W-1:0] rd_attr_reg;

    logic [CURSOR_W-1:0] out_cursor_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic [ATTR_W-1:0]   out_attr_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              accept;
    logic              out_free;
    logic              in_t_ok;
    logic [TIDX_W-1:0] in_tidx;
    logic [CUR_W:0]    div_divisor;
    logic [CUR_W:0]    div_diff;
    logic              div_ge;
    logic [COL_W-1:0]  col_inc;
    logic [MOD_W-1:0]  mod_inc;
    logic              fill_stop;
    logic              ctrl_char;
    logic              in_range;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_t_ok   = int'(terminal) < TERMINALS;
    assign in_tidx   = TIDX_W'(terminal);

    // Shared compare-and-subtract unit for the column and tab-stop remainders.
    assign div_divisor = (state_reg == ST_MOD) ? (CUR_W + 1)'(TAB_STOP)
                                               : (CUR_W + 1)'(COLUMNS);
    assign div_diff    = {1'b0, rem_reg} - div_divisor;
    assign div_ge      = !div_diff[CUR_W];

    assign col_inc   = col_reg + COL_W'(1);
    assign mod_inc   = mod_reg + MOD_W'(1);
    assign fill_stop = (col_inc == COL_W'(COLUMNS))
                    || ((ch_reg == CH_TAB) && (mod_inc == MOD_W'(TAB_STOP)));
    assign ctrl_char = (ch_reg == CH_NEWLINE) || (ch_reg == CH_RETURN)
                    || (ch_reg == CH_TAB);
    assign in_range  = ({1'b0, row_in_reg} < (POS_W + 1)'(ROWS))
                    && ({1'b0, col_in_reg} < (POS_W + 1)'(COLUMNS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (init_ptr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!t_ok_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (cmd_reg == CMD_PUT || cmd_reg == CMD_PUT_ATTR)
                begin
                    state_next = (cur_reg == CUR_W'(SCREEN_SIZE)) ? ST_SCROLL_RD
                                                                   : ST_DISPATCH;
                end
                else if (cmd_reg == CMD_SET_CURSOR || cmd_reg == CMD_READ)
                begin
                    state_next = ST_MUL;
                end
                else if (cmd_reg == CMD_CLEAR)
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL_RD:
            begin
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR:
            begin
                state_next = (ptr_reg == CUR_W'(SCREEN_SIZE - COLUMNS - 1)) ? ST_BLANK
                                                                            : ST_SCROLL_RD;
            end
            ST_BLANK:
            begin
                if (ptr_reg == CUR_W'(SCREEN_SIZE - 1))
                begin
                    state_next = (cmd_reg == CMD_CLEAR) ? ST_DONE : ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ctrl_char ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (!div_ge)
                begin
                    priority if (ch_reg == CH_TAB)
                    begin
                        state_next = ST_MOD;
                    end
                    else if (ch_reg == CH_NEWLINE)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MOD:
            begin
                if (!div_ge)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (fill_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                priority if (cmd_reg == CMD_SET_CURSOR)
                begin
                    state_next = ST_SET;
                end
                else if (in_range)
                begin
                    state_next = ST_RD_REQ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SET:
            begin
                state_next = ST_DONE;
            end
            ST_RD_REQ:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = base_reg + AW'(cur_reg);
        ram_wdata = {wattr_reg, CH_BLANK};
        ram_re    = 1'b0;
        ram_raddr = base_reg + AW'(ptr_reg) + AW'(COLUMNS);
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_ptr_reg;
                ram_wdata = '0;
            end
            ST_SCROLL_RD:
            begin
                ram_re = 1'b1;
            end
            ST_SCROLL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = base_reg + AW'(ptr_reg);
                ram_wdata = ram_rdata;
            end
            ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = base_reg + AW'(ptr_reg);
                ram_wdata = {cattr_reg, CH_BLANK};
            end
            ST_DISPATCH:
            begin
                ram_we    = !ctrl_char && (ch_reg != CH_BACKSPACE);
                ram_wdata = {wattr_reg, ch_reg};
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
            end
            ST_RD_REQ:
            begin
                ram_re    = 1'b1;
                ram_raddr = base_reg + AW'(prod_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
            t_ok_reg      <= 1'b0;
            for (int i = 0; i < TERMINALS; i++)
            begin
                cursor_pos_reg[i] <= '0;
                cur_attr_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT)
            begin
                init_ptr_reg <= init_ptr_reg + AW'(1);
            end
            if (accept)
            begin
                t_ok_reg <= in_t_ok;
            end
            if (state_reg == ST_DECODE && t_ok_reg && cmd_reg == CMD_SET_ATTR)
            begin
                cur_attr_reg[tsel_reg] <= wattr_reg;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (t_ok_reg)
                begin
                    cursor_pos_reg[tsel_reg] <= cur_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg     <= command;
                    ch_reg      <= ch;
                    row_in_reg  <= row;
                    col_in_reg  <= col;
                    tsel_reg    <= in_tidx;
                    base_reg    <= terminal ? AW'(SCREEN_SIZE) : '0;
                    rd_char_reg <= '0;
                    rd_attr_reg <= '0;
                    cur_reg     <= in_t_ok ? cursor_pos_reg[in_tidx] : '0;
                    cattr_reg   <= in_t_ok ? cur_attr_reg[in_tidx] : '0;
                    wattr_reg   <= (in_t_ok && command == CMD_PUT) ? cur_attr_reg[in_tidx]
                                                                    : attribute;
                end
            end
            ST_DECODE:
            begin
                ptr_reg <= '0;
                if (cmd_reg == CMD_CLEAR)
                begin
                    cur_reg <= '0;
                end
            end
            ST_SCROLL_WR:
            begin
                ptr_reg <= ptr_reg + CUR_W'(1);
            end
            ST_BLANK:
            begin
                ptr_reg <= ptr_reg + CUR_W'(1);
                if (cmd_reg != CMD_CLEAR)
                begin
                    cur_reg <= CUR_W'(SCREEN_SIZE - COLUMNS);
                end
            end
            ST_DISPATCH:
            begin
                rem_reg <= cur_reg;
                if (ch_reg == CH_BACKSPACE)
                begin
                    cur_reg <= (cur_reg == '0) ? CUR_W'(COLUMNS - 1) : cur_reg - CUR_W'(1);
                end
                else if (!ctrl_char)
                begin
                    cur_reg <= cur_reg + CUR_W'(1);
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_reg <= div_diff[CUR_W-1:0];
                end
                else
                begin
                    col_reg <= COL_W'(rem_reg);
                    mod_reg <= '0;
                    if (ch_reg == CH_RETURN)
                    begin
                        cur_reg <= cur_reg - rem_reg;
                    end
                end
            end
            ST_MOD:
            begin
                if (div_ge)
                begin
                    rem_reg <= div_diff[CUR_W-1:0];
                end
                else
                begin
                    mod_reg <= MOD_W'(rem_reg);
                end
            end
            ST_FILL:
            begin
                cur_reg <= cur_reg + CUR_W'(1);
                col_reg <= col_inc;
                mod_reg <= (mod_inc == MOD_W'(TAB_STOP)) ? '0 : mod_inc;
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(row_in_reg) * PROD_W'(COLUMNS) + PROD_W'(col_in_reg);
            end
            ST_SET:
            begin
                cur_reg <= (prod_reg > PROD_W'(SCREEN_SIZE)) ? CUR_W'(SCREEN_SIZE)
                                                            : CUR_W'(prod_reg);
            end
            ST_RD_DATA:
            begin
                rd_char_reg <= ram_rdata[CHAR_W-1:0];
                rd_attr_reg <= ram_rdata[CELL_W-1:CHAR_W];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_cursor_reg <= CURSOR_W'(cur_reg);
                    out_char_reg   <= rd_char_reg;
                    out_attr_reg   <= rd_attr_reg;
                end
            end
            default:
            begin
                ptr_reg <= ptr_reg;
            end
        endcase
    end

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign cursor         = out_cursor_reg;
    assign cell_char      = out_char_reg;
    assign cell_attribute = out_attr_reg;

endmodule
`default_nettype wire

// ===== dv/text_console_character_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_character_engine_tb: self-checking bench for the console engine
// Drives command transfers with bursts and gaps, stalls the result channel on
// a shifting pattern, and checks every result against a cell-level model of
// all screens, cursors and attributes. A directed opening covers control
// characters, clamping, scrolling, clearing and out-of-range reads; a random
// stream of typed text, reads and noise follows.
// ----------------------------------------------------------------------------
import tcce_pkg::*;

typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              terminal;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attribute;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
} console_cmd_t;

typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attribute;
} console_result_t;

class console_scoreboard;
    localparam int COLS    = COLUMNS_DEF;
    localparam int ROWS    = ROWS_DEF;
    localparam int SCREENS = TERMINALS_DEF;
    localparam int TAB     = TAB_STOP_DEF;
    localparam int CELLS   = ROWS * COLS;
    localparam int REPORT_LIMIT = 100;

    logic [CELL_W-1:0] cells [SCREENS][CELLS];
    int unsigned       cursor_pos [SCREENS];
    logic [ATTR_W-1:0] cur_attr [SCREENS];
    console_result_t   pending [$];
    int unsigned       failures;

    function new();
        for (int t = 0; t < SCREENS; t++)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                cells[t][i] = '0;
            end
            cursor_pos[t] = 0;
            cur_attr[t] = '0;
        end
        failures = 0;
    endfunction

    function void put_cell(int t, logic [CHAR_W-1:0] c, logic [ATTR_W-1:0] a);
        if (cursor_pos[t] < CELLS)
        begin
            cells[t][cursor_pos[t]] = {a, c};
        end
        cursor_pos[t]++;
    endfunction

    function void put_char(int t, logic [CHAR_W-1:0] c, logic [ATTR_W-1:0] a);
        int unsigned r;
        int unsigned cl;
        int unsigned stop;
        if (cursor_pos[t] >= CELLS)
        begin
            for (int i = 0; i < CELLS - COLS; i++)
            begin
                cells[t][i] = cells[t][i + COLS];
            end
            for (int i = CELLS - COLS; i < CELLS; i++)
            begin
                cells[t][i] = {cur_attr[t], CH_BLANK};
            end
            cursor_pos[t] = CELLS - COLS;
        end
        r = cursor_pos[t] / COLS;
        cl = cursor_pos[t] % COLS;
        case (c)
            CH_NEWLINE:
            begin
                stop = (r + 1) * COLS;
                while (cursor_pos[t] < stop)
                begin
                    put_cell(t, CH_BLANK, a);
                end
            end
            CH_RETURN:
            begin
                cursor_pos[t] = r * COLS;
            end
            CH_BACKSPACE:
            begin
                if (cl == 0)
                begin
                    if (r > 0)
                    begin
                        r--;
                    end
                    cl = COLS - 1;
                end
                else
                begin
                    cl--;
                end
                cursor_pos[t] = r * COLS + cl;
            end
            CH_TAB:
            begin
                do
                begin
                    put_cell(t, CH_BLANK, a);
                    cl++;
                end
                while (cl < COLS && (cl % TAB) != 0);
            end
            default:
            begin
                put_cell(t, c, a);
            end
        endcase
    endfunction

    function void note_command(console_cmd_t item);
        console_result_t res;
        int t;
        int unsigned pos;
        t = item.terminal;
        res = '0;
        case (item.command)
            CMD_PUT:
            begin
                put_char(t, item.ch, cur_attr[t]);
            end
            CMD_PUT_ATTR:
            begin
                put_char(t, item.ch, item.attribute);
            end
            CMD_SET_CURSOR:
            begin
                pos = item.row * COLS + item.col;
                cursor_pos[t] = (pos > CELLS) ? CELLS : pos;
            end
            CMD_SET_ATTR:
            begin
                cur_attr[t] = item.attribute;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    cells[t][i] = {cur_attr[t], CH_BLANK};
                end
                cursor_pos[t] = 0;
            end
            CMD_READ:
            begin
                if (item.row < ROWS && item.col < COLS)
                begin
                    pos = item.row * COLS + item.col;
                    res.cell_char = cells[t][pos][CHAR_W-1:0];
                    res.cell_attribute = cells[t][pos][CELL_W-1:CHAR_W];
                end
            end
            default:
            begin
            end
        endcase
        res.cursor = CURSOR_W'(cursor_pos[t]);
        pending.push_back(res);
    endfunction

    function void check_result(console_result_t got);
        console_result_t want;
        if (pending.size() == 0)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("%0t: unexpected result: expected none, actual cursor %0d char %0d attribute %0d",
                         $time, got.cursor, got.cell_char, got.cell_attribute);
            end
            return;
        end
        want = pending.pop_front();
        if (got.cursor !== want.cursor)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("%0t: cursor mismatch: expected %0d, actual %0d",
                         $time, want.cursor, got.cursor);
            end
        end
        if (got.cell_char !== want.cell_char)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("%0t: cell_char mismatch: expected %0d, actual %0d",
                         $time, want.cell_char, got.cell_char);
            end
        end
        if (got.cell_attribute !== want.cell_attribute)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("%0t: cell_attribute mismatch: expected %0d, actual %0d",
                         $time, want.cell_attribute, got.cell_attribute);
            end
        end
    endfunction
endclass

module text_console_character_engine_tb;

    localparam int COLS  = COLUMNS_DEF;
    localparam int ROWS  = ROWS_DEF;
    localparam int CELLS = ROWS * COLS;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    localparam int RANDOM_COMMANDS = 1830;
    localparam int SCROLL_BUDGET   = 100;
    localparam int CLEAR_BUDGET    = 40;
    localparam int IDLE_LIMIT      = 20000;
    localparam int DRAIN_CYCLES    = 32;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    command = '0;
    logic                terminal = 1'b0;
    logic [CHAR_W-1:0]   ch = '0;
    logic [ATTR_W-1:0]   attribute = '0;
    logic [POS_W-1:0]    row = '0;
    logic [POS_W-1:0]    col = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attribute;

    console_scoreboard sb;

    int unsigned text_left = 0;
    logic        text_term = 1'b0;
    int unsigned scrolls_left = SCROLL_BUDGET;
    int unsigned clears_left = CLEAR_BUDGET;
    int unsigned quiet_cycles = 0;
    int unsigned ready_mode = 0;
    int unsigned ready_left = 0;
    int unsigned ready_phase = 0;

    text_console_character_engine #(
        .COLUMNS   (COLUMNS_DEF),
        .ROWS      (ROWS_DEF),
        .TERMINALS (TERMINALS_DEF),
        .TAB_STOP  (TAB_STOP_DEF)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .terminal       (terminal),
        .ch             (ch),
        .attribute      (attribute),
        .row            (row),
        .col            (col),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor         (cursor),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic console_cmd_t make_command(logic [CMD_W-1:0] c, logic t,
                                                  logic [CHAR_W-1:0] chr,
                                                  logic [ATTR_W-1:0] a,
                                                  logic [POS_W-1:0] r,
                                                  logic [POS_W-1:0] cl);
        console_cmd_t item;
        item.command = c;
        item.terminal = t;
        item.ch = chr;
        item.attribute = a;
        item.row = r;
        item.col = cl;
        return item;
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return CH_NEWLINE;
            1: return CH_TAB;
            2: return CH_RETURN;
            3: return CH_BACKSPACE;
            4: return CHAR_W'($urandom);
            default: return CHAR_W'($urandom_range(32, 126));
        endcase
    endfunction

    task automatic next_random_command(output console_cmd_t item);
        int unsigned sel;
        int unsigned pos;
        logic term;
        sel = $urandom_range(0, 99);
        term = 1'($urandom_range(0, 1));
        if (text_left > 0)
        begin
            text_left--;
            item = make_command($urandom_range(0, 1) ? CMD_PUT_ATTR : CMD_PUT, text_term,
                                random_char(), ATTR_W'($urandom), POS_W'($urandom),
                                POS_W'($urandom));
        end
        else if (sel < 30)
        begin
            text_term = term;
            text_left = $urandom_range(2, 16);
            item = make_command(CMD_SET_CURSOR, term, CHAR_W'($urandom), ATTR_W'($urandom),
                                POS_W'($urandom_range(0, ROWS - 1)),
                                POS_W'($urandom_range(0, COLS - 1)));
        end
        else if (sel < 45)
        begin
            pos = sb.cursor_pos[term];
            if (pos > 0)
            begin
                pos = pos - $urandom_range(1, (pos < 12) ? pos : 12);
            end
            item = make_command(CMD_READ, term, CHAR_W'($urandom), ATTR_W'($urandom),
                                POS_W'(pos / COLS), POS_W'(pos % COLS));
        end
        else if (sel < 52)
        begin
            item = make_command(CMD_READ, term, CHAR_W'($urandom), ATTR_W'($urandom),
                                POS_W'($urandom_range(0, ROWS)),
                                POS_W'($urandom_range(0, COLS)));
        end
        else if (sel < 60)
        begin
            item = make_command(CMD_SET_ATTR, term, CHAR_W'($urandom), ATTR_W'($urandom),
                                POS_W'($urandom), POS_W'($urandom));
        end
        else if (sel < 62)
        begin
            item = make_command(CMD_CLEAR, term, CHAR_W'($urandom), ATTR_W'($urandom),
                                POS_W'($urandom), POS_W'($urandom));
        end
        else if (sel < 72)
        begin
            item = make_command($urandom_range(0, 1) ? CMD_PUT_ATTR : CMD_PUT, term,
                                random_char(), ATTR_W'($urandom), POS_W'($urandom),
                                POS_W'($urandom));
        end
        else
        begin
            item = make_command(CMD_W'($urandom), term, CHAR_W'($urandom), ATTR_W'($urandom),
                                POS_W'($urandom), POS_W'($urandom));
        end

        // A put on a full screen costs a whole scroll, so their number is rationed.
        if ((item.command == CMD_PUT || item.command == CMD_PUT_ATTR) &&
            sb.cursor_pos[item.terminal] >= CELLS)
        begin
            if (scrolls_left > 0)
            begin
                scrolls_left--;
            end
            else
            begin
                item.command = CMD_SET_CURSOR;
                item.row = POS_W'($urandom_range(0, ROWS - 1));
                item.col = POS_W'($urandom_range(0, COLS - 1));
            end
        end
        if (item.command == CMD_CLEAR)
        begin
            if (clears_left > 0)
            begin
                clears_left--;
            end
            else
            begin
                item.command = CMD_SET_ATTR;
            end
        end
    endtask

    task automatic send_command(input console_cmd_t item);
        in_valid = 1'b1;
        command = item.command;
        terminal = item.terminal;
        ch = item.ch;
        attribute = item.attribute;
        row = item.row;
        col = item.col;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_command({command, terminal, ch, attribute, row, col});
            end
            if (out_valid && out_ready)
            begin
                sb.check_result({cursor, cell_char, cell_attribute});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 300);
        end
        else
        begin
            ready_left--;
        end
        ready_phase++;
        case (ready_mode)
            0: out_ready = 1'b1;
            1: out_ready = ($urandom_range(0, 3) != 0);
            2: out_ready = ($urandom_range(0, 3) == 0);
            default: out_ready = ((ready_phase % 9) >= 5);
        endcase
    end

    initial
    begin
        console_cmd_t directed [$];
        console_cmd_t item;
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;

        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed.push_back(make_command(CMD_READ, 1'b0, 8'h00, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_READ, 1'b1, 8'hFF, 8'hFF, 8'd24, 8'd79));
        directed.push_back(make_command(CMD_READ, 1'b0, 8'h00, 8'h00, 8'd25, 8'd0));
        directed.push_back(make_command(CMD_READ, 1'b0, 8'h00, 8'h00, 8'd0, 8'd80));
        directed.push_back(make_command(CMD_SET_ATTR, 1'b0, 8'h00, 8'hFF, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_PUT, 1'b0, 8'h41, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_PUT_ATTR, 1'b0, 8'hFF, 8'h00, 8'hFF, 8'hFF));
        directed.push_back(make_command(CMD_PUT, 1'b0, 8'h00, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_PUT, 1'b0, CH_TAB, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_PUT_ATTR, 1'b0, CH_NEWLINE, 8'h3C, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_PUT, 1'b0, 8'h78, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_PUT, 1'b0, CH_RETURN, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_PUT, 1'b0, CH_BACKSPACE, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_SET_CURSOR, 1'b0, 8'h00, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_PUT, 1'b0, CH_BACKSPACE, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_SET_CURSOR, 1'b0, 8'h00, 8'h00, 8'd0, 8'd77));
        directed.push_back(make_command(CMD_PUT, 1'b0, CH_TAB, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_READ, 1'b0, 8'h00, 8'h00, 8'd0, 8'd78));
        directed.push_back(make_command(CMD_SET_CURSOR, 1'b0, 8'h00, 8'h00, 8'd255, 8'd255));
        directed.push_back(make_command(CMD_PUT_ATTR, 1'b0, 8'h5A, 8'hA5, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_READ, 1'b0, 8'h00, 8'h00, 8'd24, 8'd0));
        directed.push_back(make_command(CMD_READ, 1'b0, 8'h00, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_SET_CURSOR, 1'b0, 8'h00, 8'h00, 8'd24, 8'd79));
        directed.push_back(make_command(CMD_PUT, 1'b0, CH_NEWLINE, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_SET_CURSOR, 1'b1, 8'h00, 8'h00, 8'd24, 8'd80));
        directed.push_back(make_command(CMD_SET_ATTR, 1'b1, 8'h00, 8'h5A, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_CLEAR, 1'b1, 8'h00, 8'h00, 8'd0, 8'd0));
        directed.push_back(make_command(CMD_READ, 1'b1, 8'h00, 8'h00, 8'd10, 8'd10));
        directed.push_back(make_command(CMD_UNUSED_LO, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(make_command(CMD_UNUSED_HI, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

        foreach (directed[i])
        begin
            send_command(directed[i]);
        end

        sent = 0;
        while (sent < RANDOM_COMMANDS)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < RANDOM_COMMANDS; i++)
            begin
                next_random_command(item);
                send_command(item);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid = 1'b0;

        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
